@@ hdl/lcir_pkg.sv @@
package lcir_pkg;

  localparam int unsigned FIELD_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ACT_W    = 5;
  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [ACT_W-1:0]    ACT_RESET    = 5'd1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMMETRIC_IO = 2'd0,
    REG_BALANCE_EN   = 2'd1,
    REG_ACTIVE_CORES = 2'd2,
    REG_PERIOD       = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

endpackage

@@ hdl/lcir_if.sv @@
interface lcir_in_if;
  logic                    valid;
  logic                    ready;
  logic [lcir_pkg::FIELD_W-1:0] irq_line;
  logic [lcir_pkg::FIELD_W-1:0] serving_core;

  modport source (output valid, output irq_line, output serving_core, input ready);
  modport sink   (input valid, input irq_line, input serving_core, output ready);
endinterface

interface lcir_out_if;
  logic                    valid;
  logic                    ready;
  logic                    eoi_to_local_apic;
  logic                    route_valid;
  logic [lcir_pkg::FIELD_W-1:0] route_irq;
  logic [lcir_pkg::FIELD_W-1:0] route_core;
  logic                    counts_cleared;

  modport source (output valid, output eoi_to_local_apic, output route_valid,
                  output route_irq, output route_core, output counts_cleared,
                  input ready);
  modport sink   (input valid, input eoi_to_local_apic, input route_valid,
                  input route_irq, input route_core, input counts_cleared,
                  output ready);
endinterface

@@ hdl/lcir_ram.sv @@
module lcir_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/least_count_interrupt_router_unit.sv @@
// Serviced-interrupt router with per-core, per-line service counts.
// req_i carries one serviced interrupt (irq_line, serving_core); rsp_o
// returns exactly one result per request: the EOI target, and when the
// line was rebalanced, the new route and whether its counts were cleared.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// while no request is in flight.
// One request is processed at a time; req_i.ready is high only when idle.
// From accept, a request passes through ST_READ (count read, write
// back) and then ST_EMIT when balancing is off, the period is zero or
// the count wraps to zero; a line or core out of range goes straight
// to ST_EMIT. With balancing on, ST_DIV runs the remainder unit
// (4 dividend bits a cycle); on a period boundary ST_SCAN reads the
// count RAM for min(active_cores, MAX_CORES) cores (one read a cycle).
// The next request is taken once the unit is back in idle after its
// result is held.
// Reset clears the configuration to its defaults and all per-entry valid
// bits, so every count reads as zero at once; no clearing pass is needed.
// The result sits in an output register: if rsp_o stalls, the next
// request is still accepted and runs until its own result is ready.
module least_count_interrupt_router_unit #(
  parameter int unsigned MAX_CORES   = 16,
  parameter int unsigned IRQ_LINES   = 16,
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  lcir_pkg::cfg_idx_t  cfg_idx_i,
  input  lcir_pkg::cfg_data_t cfg_data_i,
  lcir_in_if.sink            req_i,
  lcir_out_if.source         rsp_o
);

  import lcir_pkg::*;

  localparam int unsigned CW        = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int unsigned LW        = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
  localparam int unsigned AW        = CW + LW;
  localparam int unsigned DEPTH     = 2 ** AW;
  localparam int unsigned NW        = $clog2(MAX_CORES + 1);
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = (COUNT_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int unsigned SW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [COUNT_WIDTH-1:0] CNT_ALL_ONES = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_BEST_INIT = CNT_ALL_ONES - COUNT_WIDTH'(1);

  // configuration
  logic                sym_q, bal_q;
  logic [ACT_W-1:0]    act_q;
  logic [PERIOD_W-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q    <= 1'b0;
      bal_q    <= 1'b0;
      act_q    <= ACT_RESET;
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SYMMETRIC_IO: sym_q    <= cfg_data_i[0];
        REG_BALANCE_EN:   bal_q    <= cfg_data_i[0];
        REG_ACTIVE_CORES: act_q    <= cfg_data_i[ACT_W-1:0];
        REG_PERIOD:       period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // count memory with one valid bit per entry; invalid reads as zero
  state_e                 state_q, state_d;
  logic [DEPTH-1:0]       vld_q;
  logic [FIELD_W-1:0]     line_q, core_q;
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr, ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  lcir_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(DEPTH)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // scan bookkeeping
  logic [NW-1:0]          issue_q;
  logic                   pend_q;
  logic [CW-1:0]          pend_idx_q;
  logic [COUNT_WIDTH-1:0] best_q;
  logic [CW-1:0]          pick_q;
  logic                   clear_q;
  logic                   rv_q;
  logic [NW-1:0]          scan_n;
  logic                   scan_done;
  logic [COUNT_WIDTH-1:0] scan_val;

  // remainder unit
  logic [DIV_W-1:0]    dvd_q;
  logic [PERIOD_W-1:0] rem_q, rem_next;
  logic [SW-1:0]       step_q;

  // output register
  logic               out_vld_q;
  logic               out_eoi_q, out_rv_q, out_clr_q;
  logic [FIELD_W-1:0] out_irq_q, out_core_q;

  logic                   in_range;
  logic [AW-1:0]          cur_addr;
  logic [COUNT_WIDTH-1:0] cur_val, cnt_inc;
  logic                   out_free;

  assign in_range = ({1'b0, req_i.irq_line} < (FIELD_W + 1)'(IRQ_LINES)) &&
                    ({1'b0, req_i.serving_core} < (FIELD_W + 1)'(MAX_CORES));
  assign cur_addr = {core_q[CW-1:0], line_q[LW-1:0]};
  assign cur_val  = vld_q[cur_addr] ? ram_rdata : '0;
  assign cnt_inc  = cur_val + COUNT_WIDTH'(1);

  assign scan_n = (act_q > ACT_W'(MAX_CORES)) ? NW'(MAX_CORES) : NW'(act_q);
  assign scan_done = (issue_q == scan_n) && !pend_q;
  assign scan_val = vld_q[{pend_idx_q, line_q[LW-1:0]}] ? ram_rdata : '0;

  assign ram_raddr = (state_q == ST_IDLE) ?
                     {req_i.serving_core[CW-1:0], req_i.irq_line[LW-1:0]} :
                     {issue_q[CW-1:0], line_q[LW-1:0]};
  assign ram_we    = (state_q == ST_READ);
  assign ram_waddr = cur_addr;
  assign ram_wdata = cnt_inc;

  // restoring remainder, DIV_BITS dividend bits a cycle
  always_comb begin
    logic [PERIOD_W:0] r;
    r = {1'b0, rem_q};
    for (int b = 0; b < DIV_BITS; b++) begin
      r = {r[PERIOD_W-1:0], dvd_q[DIV_W-1-b]};
      if (r >= {1'b0, period_q}) begin
        r = r - {1'b0, period_q};
      end
    end
    rem_next = r[PERIOD_W-1:0];
  end

  assign out_free = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = in_range ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        if (!bal_q || (cnt_inc == '0) || (period_q == '0)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == SW'(DIV_STEPS - 1)) begin
          state_d = (rem_next == '0) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      issue_q   <= '0;
      step_q    <= '0;
      rv_q      <= 1'b0;
      clear_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          rv_q    <= 1'b0;
          clear_q <= 1'b0;
        end
        ST_READ: begin
          vld_q[cur_addr] <= 1'b1;
          step_q <= '0;
        end
        ST_DIV: begin
          step_q  <= step_q + SW'(1);
          issue_q <= '0;
          pend_q  <= 1'b0;
          if (step_q == SW'(DIV_STEPS - 1)) begin
            rv_q <= (rem_next == '0);
          end
        end
        ST_SCAN: begin
          pend_q <= (issue_q != scan_n);
          if (issue_q != scan_n) begin
            issue_q <= issue_q + NW'(1);
          end
          if (pend_q && !(scan_val < best_q) && (scan_val == CNT_ALL_ONES)) begin
            clear_q <= 1'b1;
          end
          // drop the scanned cores' counts for this line
          if (scan_done && clear_q) begin
            for (int c = 0; c < MAX_CORES; c++) begin
              if (NW'(c) < scan_n) begin
                vld_q[{CW'(c), line_q[LW-1:0]}] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        line_q <= req_i.irq_line;
        core_q <= req_i.serving_core;
      end
      ST_READ: begin
        rem_q  <= '0;
        dvd_q  <= DIV_W'(cnt_inc);
      end
      ST_DIV: begin
        rem_q  <= rem_next;
        dvd_q  <= dvd_q << DIV_BITS;
        best_q <= CNT_BEST_INIT;
        pick_q <= '0;
      end
      ST_SCAN: begin
        pend_idx_q <= issue_q[CW-1:0];
        if (pend_q && (scan_val < best_q)) begin
          best_q <= scan_val;
          pick_q <= pend_idx_q;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_eoi_q  <= sym_q;
          out_rv_q   <= rv_q;
          out_irq_q  <= rv_q ? line_q : '0;
          out_core_q <= rv_q ? FIELD_W'(pick_q) : '0;
          out_clr_q  <= rv_q && clear_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.eoi_to_local_apic = out_eoi_q;
  assign rsp_o.route_valid       = out_rv_q;
  assign rsp_o.route_irq         = out_irq_q;
  assign rsp_o.route_core        = out_core_q;
  assign rsp_o.counts_cleared    = out_clr_q;

endmodule
